@@ rtl/core/pec15_pkg.sv @@
package pec15_pkg;

    localparam logic [15:0] PEC_POLY   = 16'h4599;
    localparam logic [15:0] PEC_SEED   = 16'd16;
    localparam int          MAX_GROUPS = 16;
    localparam int          GRP_W      = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       command;
        logic       first_of_group;
        logic       last_of_group;
        logic       new_transaction;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_pec_byte;
        logic             last_result;
        logic             check_done;
        logic             pec_ok;
        logic [GRP_W-1:0] group_number;
    } t_out_item;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;

    // One byte step of the CRC after the data byte is folded into the remainder.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             command;
        logic             last_of_group;
        logic [15:0]      pec;
        logic [GRP_W-1:0] group_number;
    } t_step;

    // Byte-wide table entry, built bit by bit.
    function automatic logic [15:0] pec_entry(input logic [7:0] addr);
        logic [15:0] r;
        r = {1'b0, addr, 7'b0};
        for (int b = 0; b < 8; b++) begin
            if (r[14]) begin
                r = {r[14:0], 1'b0} ^ PEC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pec15_crc_stage.sv @@
module pec15_crc_stage #(
    parameter int MAX_GROUPS = pec15_pkg::MAX_GROUPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pec15_pkg::t_in_item i_in_item,
    output logic                o_in_stall,
    input  logic                i_take,
    output logic                o_step_valid,
    output pec15_pkg::t_step    o_step
);

    localparam int GRP_W = pec15_pkg::GRP_W;
    localparam logic [GRP_W-1:0] GROUP_CAP =
        (MAX_GROUPS > 31) ? GRP_W'(31) : GRP_W'(MAX_GROUPS);

    logic                r_in_valid;
    pec15_pkg::t_in_item r_in;
    logic [15:0]         r_rem;
    logic [GRP_W-1:0]    r_grp;

    logic [15:0]      n_rem;
    logic [GRP_W-1:0] n_grp;
    logic [15:0]      rem_start;
    logic [GRP_W-1:0] grp_start;
    logic [7:0]       addr;
    logic             accept;
    logic             advance;

    assign advance    = r_in_valid && i_take;
    assign o_in_stall = r_in_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        grp_start = r_in.new_transaction ? '0 : r_grp;
        n_grp     = grp_start;
        rem_start = r_rem;
        if (r_in.first_of_group) begin
            rem_start = pec15_pkg::PEC_SEED;
            if (grp_start < GROUP_CAP) begin
                n_grp = grp_start + GRP_W'(1);
            end
        end
        addr  = rem_start[14:7] ^ r_in.data_byte;
        n_rem = {rem_start[7:0], 8'h00} ^ pec15_pkg::pec_entry(addr);
    end

    assign o_step_valid        = r_in_valid;
    assign o_step.data_byte    = r_in.data_byte;
    assign o_step.command      = r_in.command;
    assign o_step.last_of_group = r_in.last_of_group;
    assign o_step.pec          = {n_rem[14:0], 1'b0};
    assign o_step.group_number = n_grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_rem      <= pec15_pkg::PEC_SEED;
            r_grp      <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_rem <= n_rem;
                r_grp <= n_grp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
    end

endmodule

@@ rtl/core/pec15_emit.sv @@
module pec15_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step_valid,
    input  pec15_pkg::t_step     i_step,
    output logic                 o_take,
    output logic                 o_out_valid,
    output pec15_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall
);

    logic                 r_out_valid;
    pec15_pkg::t_out_item r_out;
    logic [1:0]           r_pend;
    logic [15:0]          r_pec;

    logic load;
    logic pop;

    assign o_take      = !r_out_valid || (!i_out_stall && (r_pend == 2'd0));
    assign load        = i_step_valid && o_take;
    assign pop         = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 2'd0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_pend      <= ((i_step.command == pec15_pkg::CMD_GENERATE)
                            && i_step.last_of_group) ? 2'd2 : 2'd0;
        end else if (pop) begin
            case (r_pend)
                2'd2:    r_pend <= 2'd1;
                2'd1:    r_pend <= 2'd0;
                default: r_out_valid <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pec              <= i_step.pec;
            r_out.out_byte     <= i_step.data_byte;
            r_out.is_pec_byte  <= 1'b0;
            r_out.group_number <= i_step.group_number;
            if (i_step.command == pec15_pkg::CMD_CHECK) begin
                r_out.last_result <= 1'b1;
                r_out.check_done  <= i_step.last_of_group;
                r_out.pec_ok      <= i_step.last_of_group && (i_step.pec == 16'h0000);
            end else begin
                r_out.last_result <= !i_step.last_of_group;
                r_out.check_done  <= 1'b0;
                r_out.pec_ok      <= 1'b0;
            end
        end else if (pop && (r_pend != 2'd0)) begin
            // append PEC, high byte first
            r_out.is_pec_byte <= 1'b1;
            r_out.check_done  <= 1'b0;
            r_out.pec_ok      <= 1'b0;
            if (r_pend == 2'd2) begin
                r_out.out_byte    <= r_pec[15:8];
                r_out.last_result <= 1'b0;
            end else begin
                r_out.out_byte    <= r_pec[7:0];
                r_out.last_result <= 1'b1;
            end
        end
    end

    a_pend_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> r_out_valid)
        else $error("pending PEC bytes without a valid output beat");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd3))
        else $error("pending PEC count out of range");

    a_pec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_pend != 2'd0)) |=> (r_out_valid && r_out.is_pec_byte))
        else $error("appended PEC beat missing");

    a_no_take_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> !o_take)
        else $error("new step taken while PEC bytes pending");

    a_check_not_pec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.check_done) |-> (!r_out.is_pec_byte && r_out.last_result))
        else $error("check result marked as PEC byte");

endmodule

@@ rtl/core/pec15_frame_generate_check_unit.sv @@
// An accepted beat passes the input register, then the output register, to the output.
// Throughput: one input beat per cycle unless the output stalls or a PEC byte is pending.
// A generate-mode group end yields three output beats; the input stalls for the PEC bytes.
// Input register and output register both hold a beat, so either side may stall freely.
// Reset (synchronous, active low) sets the remainder to 16, the group count to 0,
// and empties both registers.
module pec15_frame_generate_check_unit #(
    parameter int MAX_GROUPS = pec15_pkg::MAX_GROUPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  pec15_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output pec15_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall
);

    logic             take;
    logic             step_valid;
    pec15_pkg::t_step step;

    pec15_crc_stage #(
        .MAX_GROUPS(MAX_GROUPS)
    ) u_crc_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_take      (take),
        .o_step_valid(step_valid),
        .o_step      (step)
    );

    pec15_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step_valid(step_valid),
        .i_step      (step),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ tb/sv/pec15_frame_generate_check_unit_tb.sv @@
`timescale 1ns / 100ps

module pec15_frame_generate_check_unit_tb;

    localparam int GROUP_CAP =
        (pec15_pkg::MAX_GROUPS > 31) ? 31 : pec15_pkg::MAX_GROUPS;
    localparam int RANDOM_BYTES = 160;

    typedef struct {
        pec15_pkg::t_in_item beat;
        bit                  hold_for_drain;
    } t_link_byte;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    pec15_pkg::t_in_item  i_in_item = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    pec15_pkg::t_out_item o_out_item;
    logic                 i_out_stall = 1'b0;

    t_link_byte           link_bytes[$];
    pec15_pkg::t_out_item pec_beats_due[$];

    // shadow of the unit: 15-bit CRC register, group counter
    logic [14:0] crc_rem;
    logic [4:0]  group_cnt;

    int  mismatch_count = 0;
    int  stim_count = 0;
    bit  hold_next = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_cycle = 0;
    int  stall_mode = 0;

    pec15_frame_generate_check_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // bit-serial CRC-15, MSB first; bit 15 of the hardware register never shows
    function automatic logic [14:0] crc15_byte(input logic [14:0] rem, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = rem[14] ^ b[i];
            rem = {rem[13:0], 1'b0};
            if (fb) begin
                rem = rem ^ pec15_pkg::PEC_POLY[14:0];
            end
        end
        return rem;
    endfunction

    task automatic track_link_byte(input pec15_pkg::t_in_item it);
        logic [15:0] pec16;
        if (it.new_transaction) begin
            group_cnt = '0;
        end
        if (it.first_of_group) begin
            crc_rem = pec15_pkg::PEC_SEED[14:0];
            if (group_cnt < GROUP_CAP) begin
                group_cnt = group_cnt + 5'd1;
            end
        end
        crc_rem = crc15_byte(crc_rem, it.data_byte);
        pec16   = {crc_rem, 1'b0};
        if (it.command == pec15_pkg::CMD_CHECK) begin
            pec_beats_due.push_back(pec15_pkg::t_out_item'{out_byte: it.data_byte,
                is_pec_byte: 1'b0, last_result: 1'b1, check_done: it.last_of_group,
                pec_ok: it.last_of_group && (pec16 == 16'h0000), group_number: group_cnt});
        end else begin
            pec_beats_due.push_back(pec15_pkg::t_out_item'{out_byte: it.data_byte,
                is_pec_byte: 1'b0, last_result: !it.last_of_group, check_done: 1'b0,
                pec_ok: 1'b0, group_number: group_cnt});
            if (it.last_of_group) begin
                pec_beats_due.push_back(pec15_pkg::t_out_item'{out_byte: pec16[15:8],
                    is_pec_byte: 1'b1, last_result: 1'b0, check_done: 1'b0, pec_ok: 1'b0,
                    group_number: group_cnt});
                pec_beats_due.push_back(pec15_pkg::t_out_item'{out_byte: pec16[7:0],
                    is_pec_byte: 1'b1, last_result: 1'b1, check_done: 1'b0, pec_ok: 1'b0,
                    group_number: group_cnt});
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic cmd, input logic first,
                             input logic last, input logic newtx);
        t_link_byte lb;
        lb.beat = '{data_byte: data, command: cmd, first_of_group: first,
                    last_of_group: last, new_transaction: newtx};
        lb.hold_for_drain = hold_next;
        hold_next = 1'b0;
        link_bytes.push_back(lb);
        stim_count++;
    endtask

    // data bytes of one group; check groups carry their PEC, optionally with a bit error
    task automatic add_group(input logic chk, input int n_data, input logic newtx,
                             input logic corrupt, input logic skip_first);
        logic [7:0]  body[$];
        logic [14:0] rem;
        logic [15:0] pec16;
        int          k;
        rem = pec15_pkg::PEC_SEED[14:0];
        for (k = 0; k < n_data; k++) begin
            body.push_back(8'($urandom_range(0, 255)));
            rem = crc15_byte(rem, body[k]);
        end
        if (chk) begin
            pec16 = {rem, 1'b0};
            body.push_back(pec16[15:8]);
            body.push_back(pec16[7:0]);
        end
        if (corrupt) begin
            k = $urandom_range(0, body.size() - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < body.size(); k++) begin
            push_byte(body[k], chk ? pec15_pkg::CMD_CHECK : pec15_pkg::CMD_GENERATE,
                      (k == 0) && !skip_first, k == body.size() - 1, (k == 0) && newtx);
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (link_bytes.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (link_bytes[0].hold_for_drain &&
                         (i_in_valid || pec_beats_due.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_item  <= link_bytes[0].beat;
                i_in_valid <= 1'b1;
                link_bytes.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: stall pattern switches at random among four styles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_cycle++;
            if (stall_cycle % 64 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                end
                2: begin
                    i_out_stall <= (stall_cycle % 4 != 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // check the output beat first, then predict from the accepted input beat
    always @(posedge i_clk) begin : monitor
        pec15_pkg::t_out_item want;
        if (!i_rst_n) begin
            crc_rem   = pec15_pkg::PEC_SEED[14:0];
            group_cnt = '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pec_beats_due.size() == 0) begin
                    $error("unexpected output beat: out_byte 0x%0h", o_out_item.out_byte);
                    mismatch_count++;
                end else begin
                    want = pec_beats_due.pop_front();
                    check_field("out_byte", want.out_byte, o_out_item.out_byte);
                    check_field("is_pec_byte", want.is_pec_byte, o_out_item.is_pec_byte);
                    check_field("last_result", want.last_result, o_out_item.last_result);
                    check_field("check_done", want.check_done, o_out_item.check_done);
                    check_field("pec_ok", want.pec_ok, o_out_item.pec_ok);
                    check_field("group_number", want.group_number, o_out_item.group_number);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                track_link_byte(i_in_item);
            end
        end
    end

    initial begin
        #200000;
        $display("pec15_frame_generate_check_unit_tb failed");
        $finish;
    end

    initial begin
        int  directed_end;
        int  sat_runs;
        int  pick;
        bit  drained;
        sat_runs = 0;
        drained  = 1'b0;

        // no group started yet: remainder runs on from the seed, group 0
        push_byte(8'h3C, pec15_pkg::CMD_GENERATE, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, pec15_pkg::CMD_CHECK, 1'b0, 1'b1, 1'b0);
        // single-byte generate group opening a transaction
        push_byte(8'h00, pec15_pkg::CMD_GENERATE, 1'b1, 1'b1, 1'b1);
        push_byte(8'hFF, pec15_pkg::CMD_GENERATE, 1'b1, 1'b0, 1'b0);
        push_byte(8'h81, pec15_pkg::CMD_GENERATE, 1'b0, 1'b0, 1'b0);
        push_byte(8'h5A, pec15_pkg::CMD_GENERATE, 1'b0, 1'b1, 1'b0);
        add_group(pec15_pkg::CMD_CHECK, 2, 1'b1, 1'b0, 1'b0);
        add_group(pec15_pkg::CMD_CHECK, 2, 1'b0, 1'b1, 1'b0);
        // clear the count mid-group
        push_byte(8'h77, pec15_pkg::CMD_GENERATE, 1'b0, 1'b0, 1'b1);
        push_byte(8'hFF, pec15_pkg::CMD_CHECK, 1'b1, 1'b1, 1'b0);
        // check-mode byte that does not end its group, then switch mode
        push_byte(8'hC3, pec15_pkg::CMD_CHECK, 1'b1, 1'b0, 1'b0);
        push_byte(8'h18, pec15_pkg::CMD_GENERATE, 1'b0, 1'b1, 1'b0);
        hold_next = 1'b1;
        add_group(pec15_pkg::CMD_CHECK, 1, 1'b1, 1'b0, 1'b0);
        push_byte(8'hA5, pec15_pkg::CMD_GENERATE, 1'b1, 1'b1, 1'b1);
        directed_end = stim_count;

        while (stim_count - directed_end < RANDOM_BYTES) begin
            if (!drained && stim_count - directed_end > RANDOM_BYTES / 2) begin
                hold_next = 1'b1;
                drained   = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 10) begin
                add_group(pec15_pkg::CMD_GENERATE, $urandom_range(1, 5),
                          $urandom_range(0, 3) == 0, 1'b0, $urandom_range(0, 9) == 0);
            end else if (pick < 19 || sat_runs >= 2) begin
                add_group(pec15_pkg::CMD_CHECK, $urandom_range(1, 4),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                          $urandom_range(0, 9) == 0);
            end else begin
                // run the group counter into saturation
                sat_runs++;
                for (int g = 0; g < GROUP_CAP + 3; g++) begin
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b1, 1'b1, g == 0);
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (link_bytes.size() != 0 || i_in_valid || pec_beats_due.size() != 0);
        repeat (12) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("pec15_frame_generate_check_unit_tb passed");
        end else begin
            $display("pec15_frame_generate_check_unit_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pec15_pkg.sv
rtl/core/pec15_crc_stage.sv
rtl/core/pec15_emit.sv
rtl/core/pec15_frame_generate_check_unit.sv
tb/sv/pec15_frame_generate_check_unit_tb.sv
